[rtl/core/lpam_pkg.sv]
// Package for the largest-prime-at-most block.
// Holds the value width, the search constants, the sequencer states and the
// divider request/response types. Depends on nothing.
`default_nettype none

package lpam_pkg;

  localparam int VALUE_WIDTH = 31;
  localparam int CNT_W       = $clog2(VALUE_WIDTH);

  typedef logic [VALUE_WIDTH-1:0] value_t;

  localparam value_t VAL_TWO     = value_t'(2);
  localparam value_t VAL_THREE   = value_t'(3);
  localparam value_t DIV_FIRST   = value_t'(5);
  localparam value_t DIV_PAIR    = value_t'(2);
  localparam value_t DIV_STEP    = value_t'(6);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TEST,
    ST_WAIT3,
    ST_WAITD,
    ST_WAITD2,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic   start;
    value_t dividend;
    value_t divisor;
  } div_req_t;

  typedef struct packed {
    logic   done;
    value_t quotient;
    value_t remainder;
  } div_rsp_t;

endpackage

`default_nettype wire

[rtl/core/lpam_div.sv]
// Shared restoring divider, one quotient bit per cycle.
// Depends on lpam_pkg for the value width and the request/response types.
`default_nettype none

module lpam_div
  import lpam_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  logic                   busy_r, busy_nxt;
  logic                   done_r, done_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  value_t                 quo_r, quo_nxt;
  value_t                 rem_r, rem_nxt;
  value_t                 dsr_r, dsr_nxt;
  logic [VALUE_WIDTH:0]   rem_sh;
  logic [VALUE_WIDTH+1:0] diff;

  always_comb begin
    rem_sh   = {rem_r, quo_r[VALUE_WIDTH-1]};
    diff     = {1'b0, rem_sh} - {2'b00, dsr_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(VALUE_WIDTH - 1);
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      dsr_nxt  = req.divisor;
    end else if (busy_r) begin
      // The partial remainder stays below the divisor, so it fits the value width.
      if (diff[VALUE_WIDTH+1]) begin
        rem_nxt = rem_sh[VALUE_WIDTH-1:0];
        quo_nxt = {quo_r[VALUE_WIDTH-2:0], 1'b0};
      end else begin
        rem_nxt = diff[VALUE_WIDTH-1:0];
        quo_nxt = {quo_r[VALUE_WIDTH-2:0], 1'b1};
      end
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign rsp.done      = done_r;
  assign rsp.quotient  = quo_r;
  assign rsp.remainder = rem_r;

endmodule

`default_nettype wire

[rtl/core/largest_prime_at_most.sv]
// Top level of the largest-prime-at-most block: request handshakes, search
// sequencer and output register. Depends on lpam_pkg and lpam_div.
`default_nettype none

// Each request carries one unsigned value n. The block answers with the
// largest prime p <= n and a flag telling whether n itself is prime; n of 0
// or 1 yields p = 2 with the flag clear. Candidates are walked downward from
// n. A candidate of 2 or 3 is prime at once, an even one is rejected without
// a division, and any other is divided by 3 and then by d and d+2 for
// d = 5, 11, 17, ... until d exceeds the quotient c/d of the candidate c,
// which bounds d*d <= c without any wide multiply. All divisions go through
// one shared restoring divider that produces one quotient bit per cycle, and
// each decision launches the next division in the same cycle. An odd
// candidate c therefore needs about 2 + sqrt(c) / 3 divisions when it is
// prime, fewer when a small factor is found early, and the search time of a
// request is the sum over all candidates visited. A new request is taken
// only while the sequencer is idle; the finished result sits in an output
// register, so the next request can be accepted while that result is still
// stalled.
module largest_prime_at_most
  import lpam_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire logic [VALUE_WIDTH-1:0] in_value_in,
  output logic              out_valid,
  input  wire logic         out_stall,
  output logic [VALUE_WIDTH-1:0] out_prime_out,
  output logic              out_input_is_prime
);

  state_t   state_r, state_nxt;
  value_t   cand_r, cand_nxt;
  value_t   d_r, d_nxt;
  logic     first_r, first_nxt;
  logic     flag_r, flag_nxt;
  logic     out_valid_r, out_valid_nxt;
  value_t   out_prime_r, out_prime_nxt;
  logic     out_flag_r, out_flag_nxt;
  logic     in_acc;
  logic     out_free;
  div_req_t div_req;
  div_rsp_t div_rsp;

  lpam_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  // The output register can take a new result when empty or being drained.
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt        = state_r;
    cand_nxt         = cand_r;
    d_nxt            = d_r;
    first_nxt        = first_r;
    flag_nxt         = flag_r;
    out_valid_nxt    = out_valid_r && out_stall;
    out_prime_nxt    = out_prime_r;
    out_flag_nxt     = out_flag_r;
    div_req.start    = 1'b0;
    div_req.dividend = cand_r;
    div_req.divisor  = VAL_THREE;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          first_nxt = 1'b1;
          if (in_value_in <= value_t'(1)) begin
            // Zero and one are not prime; the answer is fixed at two.
            cand_nxt  = VAL_TWO;
            flag_nxt  = 1'b0;
            state_nxt = ST_FINISH;
          end else begin
            cand_nxt  = in_value_in;
            state_nxt = ST_TEST;
          end
        end
      end

      ST_TEST: begin
        if (cand_r <= VAL_THREE) begin
          if (first_r) begin
            flag_nxt = 1'b1;
          end
          state_nxt = ST_FINISH;
        end else if (!cand_r[0]) begin
          if (first_r) begin
            flag_nxt = 1'b0;
          end
          first_nxt = 1'b0;
          cand_nxt  = cand_r - value_t'(1);
        end else begin
          div_req.start   = 1'b1;
          div_req.divisor = VAL_THREE;
          state_nxt       = ST_WAIT3;
        end
      end

      ST_WAIT3: begin
        if (div_rsp.done) begin
          if (div_rsp.remainder == '0) begin
            if (first_r) begin
              flag_nxt = 1'b0;
            end
            first_nxt = 1'b0;
            cand_nxt  = cand_r - value_t'(1);
            state_nxt = ST_TEST;
          end else begin
            d_nxt           = DIV_FIRST;
            div_req.start   = 1'b1;
            div_req.divisor = DIV_FIRST;
            state_nxt       = ST_WAITD;
          end
        end
      end

      ST_WAITD: begin
        if (div_rsp.done) begin
          if (d_r > div_rsp.quotient) begin
            // No divisor up to the square root: the candidate is prime.
            if (first_r) begin
              flag_nxt = 1'b1;
            end
            state_nxt = ST_FINISH;
          end else if (div_rsp.remainder == '0) begin
            if (first_r) begin
              flag_nxt = 1'b0;
            end
            first_nxt = 1'b0;
            cand_nxt  = cand_r - value_t'(1);
            state_nxt = ST_TEST;
          end else begin
            div_req.start   = 1'b1;
            div_req.divisor = d_r + DIV_PAIR;
            state_nxt       = ST_WAITD2;
          end
        end
      end

      ST_WAITD2: begin
        if (div_rsp.done) begin
          if (div_rsp.remainder == '0) begin
            if (first_r) begin
              flag_nxt = 1'b0;
            end
            first_nxt = 1'b0;
            cand_nxt  = cand_r - value_t'(1);
            state_nxt = ST_TEST;
          end else begin
            d_nxt           = d_r + DIV_STEP;
            div_req.start   = 1'b1;
            div_req.divisor = d_r + DIV_STEP;
            state_nxt       = ST_WAITD;
          end
        end
      end

      ST_FINISH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_prime_nxt = cand_r;
          out_flag_nxt  = flag_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cand_r      <= cand_nxt;
    d_r         <= d_nxt;
    first_r     <= first_nxt;
    flag_r      <= flag_nxt;
    out_prime_r <= out_prime_nxt;
    out_flag_r  <= out_flag_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_prime_out      = out_prime_r;
  assign out_input_is_prime = out_flag_r;

`ifndef SYNTHESIS
  // The divider only reports a result while the sequencer waits for one.
  a_div_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == ST_WAIT3 || state_r == ST_WAITD ||
                      state_r == ST_WAITD2))
    else $error("divider result arrived outside a wait state");

  // A finished search with room in the output register presents its result next.
  a_finish_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FINISH && out_free) |=> (out_valid && state_r == ST_IDLE))
    else $error("finished result was not loaded into the output register");

  // Every reported answer is at least two.
  a_result_floor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_prime_out >= VAL_TWO))
    else $error("reported prime below two");

  // A flagged answer comes only from a first candidate that passed the test.
  a_flag_first: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FINISH && flag_r) |-> first_r)
    else $error("input flagged prime after the search moved below it");
`endif

endmodule

`default_nettype wire

[dv/lpam_checker.sv]
// Checker for the largest-prime-at-most block: watches both channels, predicts
// each answer from the accepted request and compares it field by field.
// Depends on lpam_pkg for the value type and the search constants.
module lpam_checker
  import lpam_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  input  logic   in_stall,
  input  value_t in_value_in,
  input  logic   out_valid,
  input  logic   out_stall,
  input  value_t out_prime_out,
  input  logic   out_input_is_prime,
  output int     fail_count,
  output int     outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    value_t request;
    value_t prime;
    logic   input_prime;
  } prime_answer_t;

  prime_answer_t expected_answers[$];
  int mismatches = 0;
  int in_flight  = 0;

  assign fail_count  = mismatches;
  assign outstanding = in_flight;

  // Trial division with the 6k-1 / 6k+1 divisor pairs. The bound d*d <= n is
  // tested as d <= n/d so that it never overflows.
  function automatic logic holds_prime(value_t n);
    longint unsigned v;
    longint unsigned d;
    v = n;
    if (v < VAL_TWO) return 1'b0;
    if (v <= VAL_THREE) return 1'b1;
    if (v % VAL_TWO == 0 || v % VAL_THREE == 0) return 1'b0;
    for (d = DIV_FIRST; d <= v / d; d += DIV_STEP) begin
      if (v % d == 0 || v % (d + DIV_PAIR) == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic prime_answer_t predict_answer(value_t n);
    prime_answer_t answer;
    value_t c;
    answer.request     = n;
    answer.prime       = VAL_TWO;
    answer.input_prime = holds_prime(n);
    if (n >= VAL_TWO) begin
      for (c = n; c > VAL_TWO; c--) begin
        if (holds_prime(c)) begin
          answer.prime = c;
          break;
        end
      end
    end
    return answer;
  endfunction

  always @(posedge clk) begin : watch_channels
    prime_answer_t want;
    if (rst_n) begin
      // The answer side is handled first: an answer can never belong to a
      // request accepted at the same edge.
      if (out_valid && !out_stall) begin
        if (expected_answers.size() == 0) begin
          if (mismatches < REPORT_LIMIT) begin
            $display("unexpected answer: prime %0d flag %0b", out_prime_out,
                     out_input_is_prime);
          end
          mismatches <= mismatches + 1;
        end else begin
          want = expected_answers.pop_front();
          if (out_prime_out !== want.prime ||
              out_input_is_prime !== want.input_prime) begin
            if (mismatches < REPORT_LIMIT) begin
              $display("request %0d: expected prime %0d flag %0b, got prime %0d flag %0b",
                       want.request, want.prime, want.input_prime, out_prime_out,
                       out_input_is_prime);
            end
            mismatches <= mismatches + 1;
          end
        end
      end
      if (in_valid && !in_stall) begin
        expected_answers.push_back(predict_answer(in_value_in));
      end
      in_flight <= expected_answers.size();
    end
  end

endmodule

[dv/testbench.sv]
// Top of the largest-prime-at-most testbench: clock, reset, request stimulus,
// answer-side stalls, watchdog and verdict. Depends on lpam_pkg, the
// largest_prime_at_most block and lpam_checker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import lpam_pkg::*;

  // The only full-width request is by far the slowest (a prime near 2^31
  // needs roughly 15k divisions), so the watchdog allows several times its
  // search time with no handshake on either channel.
  localparam int WATCHDOG_LIMIT = 2_500_000;
  localparam int DRAIN_CYCLES   = 200;
  localparam int RANDOM_COUNT   = 80;
  localparam int IDLE_PERCENT   = 26;
  localparam int CORNER_COUNT   = 21;

  logic   clk         = 1'b0;
  logic   rst_n       = 1'b0;
  logic   in_valid    = 1'b0;
  value_t in_value_in = '0;
  logic   out_stall   = 1'b0;
  logic   calm        = 1'b0;

  logic   in_stall;
  logic   out_valid;
  value_t out_prime_out;
  logic   out_input_is_prime;
  int     fail_count;
  int     outstanding;

  // Directed requests: the bottom of the range where the answer is pinned to
  // two, the small primes that are taken at once, even and multiple-of-three
  // rejects, squares and products of a 6k-1 / 6k+1 divisor pair (where the
  // d <= n/d bound is exactly met), a power of two, and the largest value,
  // which is itself prime and sets every input bit.
  value_t corner_values [CORNER_COUNT] = '{
    31'd0, 31'd1, 31'd2, 31'd3, 31'd4, 31'd5, 31'd6, 31'd7, 31'd8, 31'd9,
    31'd24, 31'd25, 31'd35, 31'd49, 31'd121, 31'd143, 31'd289, 31'd323,
    31'd7919, 31'd65536, 31'h7FFF_FFFF
  };

  largest_prime_at_most i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_value_in       (in_value_in),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_prime_out     (out_prime_out),
    .out_input_is_prime(out_input_is_prime)
  );

  lpam_checker i_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_value_in       (in_value_in),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_prime_out     (out_prime_out),
    .out_input_is_prime(out_input_is_prime),
    .fail_count        (fail_count),
    .outstanding       (outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The answer side stalls about a quarter of the time, except during the
  // calm stretch where both sides run flat out.
  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < IDLE_PERCENT);
  end

  // The search time grows with the square root of the value, so most random
  // requests are small; a few reach into the millions. Tiny values are drawn
  // on their own so that the pinned-to-two cases keep coming up.
  function automatic value_t random_value();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 10) return value_t'($urandom_range(15));
    if (pick < 70) return value_t'($urandom_range(4095));
    if (pick < 95) return value_t'($urandom_range(262143));
    return value_t'($urandom_range(4194303));
  endfunction

  // Offers one request and returns at the edge where it is accepted. Valid
  // is lowered only inside the idle loop, so back-to-back requests keep it
  // high without a second assignment in the same time step.
  task automatic send_request(input value_t value);
    while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
      in_valid    <= 1'b0;
      in_value_in <= value_t'($urandom);
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_value_in <= value;
    do @(posedge clk); while (in_stall);
  endtask

  // Holds off new requests until every predicted answer has come back.
  task automatic drain_answers();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  initial begin : stimulus
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (corner_values[i]) begin
      send_request(corner_values[i]);
    end
    drain_answers();

    for (int k = 0; k < RANDOM_COUNT; k++) begin
      calm <= (k >= 30 && k < 60);
      // A second full pause in the middle of the random requests.
      if (k == 50) begin
        drain_answers();
      end
      send_request(random_value());
    end

    drain_answers();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Ends the run when neither channel has moved for too long, which also
  // covers answers that never arrive.
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("Regression FAIL");
    $finish;
  end

endmodule
